// File: hw/rtl/pnf_pkg.sv
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared types, constants and arithmetic helpers for the fBm Perlin noise block.
// ----------------------------------------------------------------------------
package pnf_pkg;

	localparam int PERM_AW     = 8;
	localparam int MAX_OCTAVES = 8;
	localparam int FRAC_BITS   = 16;
	localparam int LAST_STEP   = 24;
	localparam int DIV_STEPS   = 21;

	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_PERM = 1'b1;

	localparam logic REG_OCTAVES   = 1'b0;
	localparam logic REG_BASE_FREQ = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OCT,
		ST_DIV,
		ST_DONE
	} pnf_state_t;

	// 6t^5 - 15t^4 + 10t^3, clamped to [0, 1.0]
	function automatic logic [FRAC_BITS:0] fade_mix(logic [FRAC_BITS-1:0] t3,
		logic [FRAC_BITS-1:0] t4, logic [FRAC_BITS-1:0] t5);
		logic signed [FRAC_BITS+5:0] f;
		f = $signed({6'd0, t5}) * 22'sd6 - $signed({6'd0, t4}) * 22'sd15
			+ $signed({6'd0, t3}) * 22'sd10;
		if (f < 0) begin
			return '0;
		end else if (f > (22'sd1 <<< FRAC_BITS)) begin
			return {1'b1, {FRAC_BITS{1'b0}}};
		end else begin
			return f[FRAC_BITS:0];
		end
	endfunction

	// 16-way gradient dot product; ox/oy/oz select the far corner (frac - 1.0)
	function automatic logic signed [FRAC_BITS+3:0] grad_fx(logic [7:0] hash,
		logic [FRAC_BITS-1:0] fx, logic [FRAC_BITS-1:0] fy, logic [FRAC_BITS-1:0] fz,
		logic ox, logic oy, logic oz);
		logic signed [FRAC_BITS+3:0] one, x, y, z, u, v;
		logic [3:0] h;
		one = 20'sd1 <<< FRAC_BITS;
		h = hash[3:0];
		x = $signed({4'd0, fx}) - (ox ? one : 20'sd0);
		y = $signed({4'd0, fy}) - (oy ? one : 20'sd0);
		z = $signed({4'd0, fz}) - (oz ? one : 20'sd0);
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

// File: hw/rtl/pnf_perm_ram.sv
// ----------------------------------------------------------------------------
// pnf_perm_ram
// 256 x 8 permutation table, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pnf_perm_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [pnf_pkg::PERM_AW-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic [pnf_pkg::PERM_AW-1:0] raddr,
	output logic [7:0]                rdata
);
	import pnf_pkg::*;

	logic [7:0] mem [0:(1 << PERM_AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/perlin_noise_3d_fbm.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_fbm
// Fractal 3D improved Perlin noise, one point per evaluate word.
//
// Input stream s_*: s_tuser is the command. cmd=1 writes one permutation
// table entry and gives no output word. cmd=0 evaluates the
// point; all 256 table entries must be written first.
// Output stream m_*: one word per evaluation, noise_value in m_tdata and the
// saturation flag in m_tuser, held in an output register until taken.
// Config channel cfg_*: index 0 octave_count, index 1 base_frequency.
// Write only while idle; cfg_ready is always high.
// An evaluation runs the octaves in turn on the shared 25x25 multiplier
// and the table read port, then a bit-serial divide by the octave count.
// s_tready is low meanwhile.
// A stalled receiver holds the finished word; the next evaluation may run
// but waits at its end until the output register is free.
// Reset clears control state and sets the config registers to defaults; the table content
// is undefined until written.
// ----------------------------------------------------------------------------
module perlin_noise_3d_fbm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// coord_x[23:0], coord_y[47:24], coord_z[71:48], perm_index[79:72],
	// perm_value[87:80]
	input  logic [87:0] s_tdata,
	// cmd[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// noise_value[15:0]
	output logic [15:0] m_tdata,
	// clipped[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_addr,
	input  logic [15:0] cfg_data
);
	import pnf_pkg::*;

	pnf_state_t st_q, st_d;

	logic [3:0]  octave_count_q;
	logic [15:0] base_freq_q;

	logic signed [23:0] cx_q, cy_q, cz_q;
	logic [3:0]  noct_q;
	logic [2:0]  oct_q;
	logic [4:0]  step_q;

	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] mul_p_q;
	logic [15:0] p16;
	logic [31:0] pos;

	logic [15:0] fx_q, fy_q, fz_q;
	logic [7:0]  xi_q, yi_q, zi_q;
	logic [16:0] sx_q, sy_q, sz_q;
	logic [15:0] t3_q, t4_q;
	logic [7:0]  xa_q, xb_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [19:0] g000_q, g100_q, g010_q, g110_q;
	logic signed [19:0] g001_q, g101_q, g011_q, g111_q;
	logic signed [19:0] l0_q, l1_q, l2_q, l3_q, front_q, rear_q;
	logic signed [19:0] lerp_v;
	logic signed [23:0] sum_q, sum_d;

	logic [20:0] dq_q;
	logic [3:0]  rem_q;
	logic [4:0]  dcnt_q;
	logic        neg_q;
	logic [4:0]  dtrial;

	logic [7:0]  raddr, rdata;
	logic        perm_we;
	logic        eval_go, last_oct, oct_end, div_end, out_load;

	logic        m_tvalid_q;
	logic [15:0] m_data_q;
	logic        m_clip_q;

	pnf_perm_ram u_perm (
		.clk   (clk),
		.we    (perm_we),
		.waddr (s_tdata[79:72]),
		.wdata (s_tdata[87:80]),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_clip_q;

	assign p16    = mul_p_q[31:16];
	assign pos    = mul_p_q[31:0] << oct_q;
	assign lerp_v = (step_q == 5'd24 ? front_q :
		step_q == 5'd22 ? l2_q : step_q == 5'd21 ? l0_q :
		step_q == 5'd20 ? g011_q : step_q == 5'd19 ? g001_q :
		step_q == 5'd18 ? g010_q : g000_q) + $signed(mul_p_q[35:16]);
	assign sum_d  = sum_q + {{4{lerp_v[19]}}, lerp_v} + (24'sd1 <<< FRAC_BITS);
	assign dtrial = {rem_q, dq_q[20]};

	assign last_oct = ({1'b0, oct_q} == noct_q - 4'd1);
	assign oct_end  = (st_q == ST_OCT) && (step_q == 5'(LAST_STEP));
	assign div_end  = (st_q == ST_DIV) && (dcnt_q == 5'(DIV_STEPS - 1));

	// control outputs
	always_comb begin
		s_tready = (st_q == ST_IDLE);
		eval_go  = s_tvalid && s_tready && (s_tuser[0] == CMD_EVAL);
		perm_we  = s_tvalid && s_tready && (s_tuser[0] == CMD_PERM);
		out_load = (st_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (eval_go) st_d = ST_OCT;
			ST_OCT:  if (oct_end && last_oct) st_d = ST_DIV;
			ST_DIV:  if (div_end) st_d = ST_DONE;
			ST_DONE: if (out_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			5'd0: begin mul_a = {cx_q[23], cx_q}; mul_b = {9'd0, base_freq_q}; end
			5'd1: begin mul_a = {cy_q[23], cy_q}; mul_b = {9'd0, base_freq_q}; end
			5'd2: begin mul_a = {cz_q[23], cz_q}; mul_b = {9'd0, base_freq_q}; end
			5'd3: begin mul_a = {9'd0, fx_q}; mul_b = {9'd0, fx_q}; end
			5'd4, 5'd5, 5'd6: begin mul_a = {9'd0, p16}; mul_b = {9'd0, fx_q}; end
			5'd7: begin mul_a = {9'd0, fy_q}; mul_b = {9'd0, fy_q}; end
			5'd8, 5'd9, 5'd10: begin mul_a = {9'd0, p16}; mul_b = {9'd0, fy_q}; end
			5'd11: begin mul_a = {9'd0, fz_q}; mul_b = {9'd0, fz_q}; end
			5'd12, 5'd13, 5'd14: begin mul_a = {9'd0, p16}; mul_b = {9'd0, fz_q}; end
			5'd16: begin mul_a = {8'd0, sx_q}; mul_b = 25'(g100_q - g000_q); end
			5'd17: begin mul_a = {8'd0, sx_q}; mul_b = 25'(g110_q - g010_q); end
			5'd18: begin mul_a = {8'd0, sx_q}; mul_b = 25'(g101_q - g001_q); end
			5'd19: begin mul_a = {8'd0, sx_q}; mul_b = 25'(g111_q - g011_q); end
			5'd20: begin mul_a = {8'd0, sy_q}; mul_b = 25'(l1_q - l0_q); end
			5'd21: begin mul_a = {8'd0, sy_q}; mul_b = 25'(l3_q - l2_q); end
			5'd23: begin mul_a = {8'd0, sz_q}; mul_b = 25'(rear_q - front_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// table read address
	always_comb begin
		case (step_q)
			5'd3:    raddr = xi_q;
			5'd4:    raddr = xi_q + 8'd1;
			5'd5:    raddr = xa_q + yi_q;
			5'd6:    raddr = xa_q + yi_q + 8'd1;
			5'd7:    raddr = xb_q + yi_q;
			5'd8:    raddr = xb_q + yi_q + 8'd1;
			5'd9:    raddr = aa_q + zi_q;
			5'd10:   raddr = ba_q + zi_q;
			5'd11:   raddr = ab_q + zi_q;
			5'd12:   raddr = bb_q + zi_q;
			5'd13:   raddr = aa_q + zi_q + 8'd1;
			5'd14:   raddr = ba_q + zi_q + 8'd1;
			5'd15:   raddr = ab_q + zi_q + 8'd1;
			5'd16:   raddr = bb_q + zi_q + 8'd1;
			default: raddr = xi_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			octave_count_q <= 4'd4;
			base_freq_q    <= 16'd6554;
			step_q         <= '0;
			oct_q          <= '0;
			dcnt_q         <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr[0])
					REG_OCTAVES:   octave_count_q <= cfg_data[3:0];
					REG_BASE_FREQ: base_freq_q    <= cfg_data;
					default: ;
				endcase
			end
			if (eval_go) begin
				step_q <= '0;
				oct_q  <= '0;
			end else if (st_q == ST_OCT) begin
				if (oct_end) begin
					step_q <= '0;
					oct_q  <= oct_q + 3'd1;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
			if (st_q != ST_DIV) begin
				dcnt_q <= '0;
			end else begin
				dcnt_q <= dcnt_q + 5'd1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (eval_go) begin
			cx_q  <= $signed(s_tdata[23:0]);
			cy_q  <= $signed(s_tdata[47:24]);
			cz_q  <= $signed(s_tdata[71:48]);
			sum_q <= '0;
			if (octave_count_q == 4'd0) begin
				noct_q <= 4'd1;
			end else if (octave_count_q > 4'(MAX_OCTAVES)) begin
				noct_q <= 4'(MAX_OCTAVES);
			end else begin
				noct_q <= octave_count_q;
			end
		end
		if (st_q == ST_OCT) begin
			case (step_q)
				5'd1: begin xi_q <= pos[31:24]; fx_q <= pos[23:8]; end
				5'd2: begin yi_q <= pos[31:24]; fy_q <= pos[23:8]; end
				5'd3: begin zi_q <= pos[31:24]; fz_q <= pos[23:8]; end
				5'd4: xa_q <= rdata;
				5'd5: begin xb_q <= rdata; t3_q <= p16; end
				5'd6: begin aa_q <= rdata; t4_q <= p16; end
				5'd7: begin ab_q <= rdata; sx_q <= fade_mix(t3_q, t4_q, p16); end
				5'd8: ba_q <= rdata;
				5'd9: begin bb_q <= rdata; t3_q <= p16; end
				5'd10: begin
					g000_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b0, 1'b0, 1'b0);
					t4_q   <= p16;
				end
				5'd11: begin
					g100_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b1, 1'b0, 1'b0);
					sy_q   <= fade_mix(t3_q, t4_q, p16);
				end
				5'd12: g010_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b0, 1'b1, 1'b0);
				5'd13: begin
					g110_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b1, 1'b1, 1'b0);
					t3_q   <= p16;
				end
				5'd14: begin
					g001_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b0, 1'b0, 1'b1);
					t4_q   <= p16;
				end
				5'd15: begin
					g101_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b1, 1'b0, 1'b1);
					sz_q   <= fade_mix(t3_q, t4_q, p16);
				end
				5'd16: g011_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b0, 1'b1, 1'b1);
				5'd17: begin
					g111_q <= grad_fx(rdata, fx_q, fy_q, fz_q, 1'b1, 1'b1, 1'b1);
					l0_q   <= lerp_v;
				end
				5'd18: l1_q    <= lerp_v;
				5'd19: l2_q    <= lerp_v;
				5'd20: l3_q    <= lerp_v;
				5'd21: front_q <= lerp_v;
				5'd22: rear_q  <= lerp_v;
				5'd24: begin
					sum_q <= sum_d;
					dq_q  <= sum_d[21:1];
					neg_q <= sum_d[23];
					rem_q <= '0;
				end
				default: ;
			endcase
		end
		if (st_q == ST_DIV) begin
			if (dtrial >= {1'b0, noct_q}) begin
				rem_q <= 4'(dtrial - {1'b0, noct_q});
				dq_q  <= {dq_q[19:0], 1'b1};
			end else begin
				rem_q <= dtrial[3:0];
				dq_q  <= {dq_q[19:0], 1'b0};
			end
		end
		if (out_load) begin
			if (neg_q) begin
				m_data_q <= '0;
				m_clip_q <= 1'b1;
			end else if (dq_q[20:16] != 5'd0) begin
				m_data_q <= 16'hFFFF;
				m_clip_q <= 1'b1;
			end else begin
				m_data_q <= dq_q[15:0];
				m_clip_q <= 1'b0;
			end
		end
	end

	a_oct_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OCT) |-> ({1'b0, oct_q} < noct_q))
		else $error("octave counter past octave count");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		eval_go |=> (st_q == ST_OCT) && (step_q == 5'd0) && (oct_q == 3'd0))
		else $error("evaluation did not start at octave zero");

	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(st_q == ST_DONE))
		else $error("output word without finished divide");

	a_noct_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (noct_q >= 4'd1) && (noct_q <= 4'(MAX_OCTAVES)))
		else $error("octave count out of range during divide");

endmodule
